### sv/kwm_pkg.sv
// Shared types, constants and control structs for the k-way merge min-heap.
package kwm_pkg;

	localparam int MAX_LISTS  = 256;
	localparam int KEY_BITS   = 32;
	localparam int SRC_BITS   = 8;
	localparam int ADDR_BITS  = $clog2(MAX_LISTS);
	localparam int CNT_BITS   = ADDR_BITS + 1;
	localparam int IDX_BITS   = ADDR_BITS + 2;
	localparam int STS_BITS   = 2;

	localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
	localparam logic [STS_BITS-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_BITS-1:0] STS_FULL  = 2'd2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef struct packed {
		logic signed [KEY_BITS-1:0] key;
		logic [SRC_BITS-1:0]        src;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_EX_ROOT,
		ST_EX_LAST,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		A_ROOT,
		A_LAST,
		A_PARENT,
		A_LEFT,
		A_RIGHT
	} addr_sel_t;

	typedef enum logic [1:0] {
		W_CUR,
		W_RD,
		W_LEFT
	} wr_sel_t;

	typedef enum logic [2:0] {
		P_HOLD,
		P_ZERO,
		P_PARENT,
		P_LEFT,
		P_RIGHT
	} pos_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                start;
		logic                start_ins;
		logic [STS_BITS-1:0] status_code;
		logic                rd_en;
		addr_sel_t           rd_sel;
		logic                wr_en;
		wr_sel_t             wr_sel;
		pos_sel_t            pos_sel;
		logic                take_root;
		logic                take_last;
		logic                take_left;
		logic                load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic up_less;
		logic left_in;
		logic right_in;
		logic go_left;
		logic go_right;
	} sts_t;

endpackage

### sv/kwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/kwm_dp.sv
// Datapath of the min-heap: entry store, moving entry, position, count and result.
module kwm_dp import kwm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic signed [KEY_BITS-1:0] in_key,
	input  logic [SRC_BITS-1:0]        in_source,
	output logic [STS_BITS-1:0]        out_status,
	output logic signed [KEY_BITS-1:0] out_key,
	output logic [SRC_BITS-1:0]        out_source,
	output logic [CNT_BITS-1:0]        out_occupancy
);

	logic [CNT_BITS-1:0]  count_q;
	logic [ADDR_BITS-1:0] pos_q;
	entry_t               cur_q;
	entry_t               lft_q;
	entry_t               res_q;
	logic [STS_BITS-1:0]  status_q;
	entry_t               rd_data;
	logic [ENTRY_BITS-1:0] rd_raw;

	logic [ADDR_BITS-1:0] pos_m1;
	logic [ADDR_BITS-1:0] parent;
	logic [CNT_BITS-1:0]  cnt_m1;
	logic [IDX_BITS-1:0]  lchild;
	logic [IDX_BITS-1:0]  rchild;
	logic [IDX_BITS-1:0]  cnt_ext;
	logic [ADDR_BITS-1:0] rd_addr;
	entry_t               wr_data;
	entry_t               best_lc;
	logic                 left_lt;

	// Index arithmetic of the heap tree.
	assign pos_m1  = pos_q - 1'b1;
	assign parent  = {1'b0, pos_m1[ADDR_BITS-1:1]};
	assign cnt_m1  = count_q - 1'b1;
	assign lchild  = {1'b0, pos_q, 1'b1};
	assign rchild  = lchild + 1'b1;
	assign cnt_ext = {1'b0, count_q};

	// Read address select.
	always_comb begin
		unique case (cmd.rd_sel)
			A_ROOT:   rd_addr = '0;
			A_LAST:   rd_addr = cnt_m1[ADDR_BITS-1:0];
			A_PARENT: rd_addr = parent;
			A_LEFT:   rd_addr = lchild[ADDR_BITS-1:0];
			A_RIGHT:  rd_addr = rchild[ADDR_BITS-1:0];
			default:  rd_addr = '0;
		endcase
	end

	// Write data select; the write always lands at the current position.
	always_comb begin
		unique case (cmd.wr_sel)
			W_CUR:   wr_data = cur_q;
			W_RD:    wr_data = rd_data;
			W_LEFT:  wr_data = lft_q;
			default: wr_data = cur_q;
		endcase
	end

	kwm_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(MAX_LISTS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(pos_q),
		.wdata(wr_data),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	assign rd_data = entry_t'(rd_raw);

	// Sift-down choice: left first, then right against the smaller so far.
	assign left_lt = lft_q.key < cur_q.key;
	assign best_lc = left_lt ? lft_q : cur_q;

	always_comb begin
		sts.full     = (count_q == CNT_BITS'(MAX_LISTS));
		sts.empty    = (count_q == '0);
		sts.pos_zero = (pos_q == '0);
		sts.up_less  = cur_q.key < rd_data.key;
		sts.left_in  = lchild < cnt_ext;
		sts.right_in = rchild < cnt_ext;
		sts.go_right = sts.right_in && (rd_data.key < best_lc.key);
		sts.go_left  = !sts.go_right && left_lt;
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_ins) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.take_root) begin
			count_q <= cnt_m1;
		end
	end

	// Position of the moving entry.
	always_ff @(posedge clk) begin
		if (cmd.start_ins) begin
			pos_q <= count_q[ADDR_BITS-1:0];
		end else begin
			unique case (cmd.pos_sel)
				P_HOLD:   pos_q <= pos_q;
				P_ZERO:   pos_q <= '0;
				P_PARENT: pos_q <= parent;
				P_LEFT:   pos_q <= lchild[ADDR_BITS-1:0];
				P_RIGHT:  pos_q <= rchild[ADDR_BITS-1:0];
				default:  pos_q <= pos_q;
			endcase
		end
	end

	// Moving entry and latched left child.
	always_ff @(posedge clk) begin
		if (cmd.start_ins) begin
			cur_q.key <= in_key;
			cur_q.src <= in_source;
		end else if (cmd.take_last) begin
			cur_q <= rd_data;
		end
		if (cmd.take_left) begin
			lft_q <= rd_data;
		end
	end

	// Result of the request in flight.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q    <= '0;
			status_q <= cmd.status_code;
		end else if (cmd.take_root) begin
			res_q <= rd_data;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status    <= status_q;
			out_key       <= res_q.key;
			out_source    <= res_q.src;
			out_occupancy <= count_q;
		end
	end

endmodule

### sv/kwm_ctrl.sv
// Controller state machine that sequences inserts, extracts and the sift loops.
module kwm_ctrl import kwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_op,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_op == OP_INSERT) begin
						state_d = sts.full ? ST_DONE : ST_UP_RD;
					end else begin
						state_d = sts.empty ? ST_DONE : ST_EX_ROOT;
					end
				end
			end
			ST_UP_RD:   state_d = sts.pos_zero ? ST_DONE : ST_UP_CMP;
			ST_UP_CMP:  state_d = sts.up_less ? ST_UP_RD : ST_DONE;
			ST_EX_ROOT: state_d = ST_EX_LAST;
			ST_EX_LAST: state_d = sts.empty ? ST_DONE : ST_DN_RDL;
			ST_DN_RDL:  state_d = sts.left_in ? ST_DN_RDR : ST_DONE;
			ST_DN_RDR:  state_d = ST_DN_CMP;
			ST_DN_CMP:  state_d = (sts.go_left || sts.go_right) ? ST_DN_RDL : ST_DONE;
			ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd             = '0;
		cmd.status_code = STS_OK;
		cmd.rd_sel      = A_ROOT;
		cmd.wr_sel      = W_CUR;
		cmd.pos_sel     = P_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					if (in_op == OP_INSERT) begin
						if (sts.full) begin
							cmd.status_code = STS_FULL;
						end else begin
							cmd.start_ins = 1'b1;
						end
					end else begin
						if (sts.empty) begin
							cmd.status_code = STS_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = A_ROOT;
						end
					end
				end
			end
			ST_UP_RD: begin
				if (sts.pos_zero) begin
					cmd.wr_en = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_PARENT;
				end
			end
			ST_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.up_less) begin
					cmd.wr_sel  = W_RD;
					cmd.pos_sel = P_PARENT;
				end
			end
			ST_EX_ROOT: begin
				cmd.take_root = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = A_LAST;
			end
			ST_EX_LAST: begin
				cmd.take_last = 1'b1;
				cmd.pos_sel   = P_ZERO;
			end
			ST_DN_RDL: begin
				if (sts.left_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_LEFT;
				end else begin
					cmd.wr_en = 1'b1;
				end
			end
			ST_DN_RDR: begin
				cmd.take_left = 1'b1;
				if (sts.right_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_RIGHT;
				end
			end
			ST_DN_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.go_right) begin
					cmd.wr_sel  = W_RD;
					cmd.pos_sel = P_RIGHT;
				end else if (sts.go_left) begin
					cmd.wr_sel  = W_LEFT;
					cmd.pos_sel = P_LEFT;
				end
			end
			ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd.load_out = 1'b0;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/k_way_merge_min_heap.sv
// Top level of the k-way merge min-heap: controller plus datapath.
//
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid / in_ready   op, key, source
//  out      source     out_valid / out_ready status, min_key, min_source, occupancy
//
// Each level of an insert reads the parent and then compares and writes; each level of
// an extract reads the left child, then the right child, then compares and writes, all
// through the single read port of the entry RAM. Error requests go from the accepting
// cycle straight to the done state, with no RAM access.
// Reset clears the entry count, the state machine and the output valid; the RAM
// needs no clearing since only entries below the count are read.
// A finished result waits in the output register; the next request is taken while
// it waits, and completes only once the register is free.
module k_way_merge_min_heap import kwm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic signed [KEY_BITS-1:0] key,
	input  logic [SRC_BITS-1:0]        source,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STS_BITS-1:0]        status,
	output logic signed [KEY_BITS-1:0] min_key,
	output logic [SRC_BITS-1:0]        min_source,
	output logic [CNT_BITS-1:0]        occupancy
);

	cmd_t cmd;
	sts_t sts;

	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_key       (key),
		.in_source    (source),
		.out_status   (status),
		.out_key      (min_key),
		.out_source   (min_source),
		.out_occupancy(occupancy)
	);

endmodule

### tb/sv/k_way_merge_min_heap_check.sv
// Checker that predicts and compares every k-way merge heap result.
module k_way_merge_min_heap_check import kwm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       op,
	input  logic signed [KEY_BITS-1:0] key,
	input  logic [SRC_BITS-1:0]        source,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [STS_BITS-1:0]        status,
	input  logic signed [KEY_BITS-1:0] min_key,
	input  logic [SRC_BITS-1:0]        min_source,
	input  logic [CNT_BITS-1:0]        occupancy,
	output int                         pending,
	output int                         errors
);

	typedef struct packed {
		logic [STS_BITS-1:0]        status;
		logic signed [KEY_BITS-1:0] min_key;
		logic [SRC_BITS-1:0]        min_source;
		logic [CNT_BITS-1:0]        occupancy;
	} heap_result_t;

	// Shadow copy of the heap kept by the predictor.
	logic signed [KEY_BITS-1:0] heap_key [MAX_LISTS];
	logic [SRC_BITS-1:0]        heap_src [MAX_LISTS];
	int                         heap_size = 0;

	// Results still owed by the block, oldest first.
	heap_result_t result_q [$];

	function automatic void swap_slots(int a, int b);
		logic signed [KEY_BITS-1:0] k;
		logic [SRC_BITS-1:0]        s;
		k = heap_key[a];
		s = heap_src[a];
		heap_key[a] = heap_key[b];
		heap_src[a] = heap_src[b];
		heap_key[b] = k;
		heap_src[b] = s;
	endfunction

	// Applies one request to the shadow heap and returns the result it must give.
	function automatic heap_result_t apply_request(logic op_v, logic signed [KEY_BITS-1:0] key_v,
			logic [SRC_BITS-1:0] src_v);
		heap_result_t res;
		int           pos;
		int           parent;
		int           best;
		res = '0;
		res.status = STS_OK;
		if (op_v == OP_EXTRACT) begin
			if (heap_size == 0) begin
				res.status = STS_EMPTY;
			end else begin
				res.min_key = heap_key[0];
				res.min_source = heap_src[0];
				heap_size--;
				heap_key[0] = heap_key[heap_size];
				heap_src[0] = heap_src[heap_size];
				// Sift down: left child is tried first, ties never move.
				pos = 0;
				while (1'b1) begin
					best = pos;
					if (2 * pos + 1 < heap_size && heap_key[2 * pos + 1] < heap_key[best])
						best = 2 * pos + 1;
					if (2 * pos + 2 < heap_size && heap_key[2 * pos + 2] < heap_key[best])
						best = 2 * pos + 2;
					if (best == pos)
						break;
					swap_slots(best, pos);
					pos = best;
				end
			end
		end else begin
			if (heap_size >= MAX_LISTS) begin
				res.status = STS_FULL;
			end else begin
				heap_key[heap_size] = key_v;
				heap_src[heap_size] = src_v;
				pos = heap_size;
				heap_size++;
				// Sift up while strictly smaller than the parent.
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!(heap_key[pos] < heap_key[parent]))
						break;
					swap_slots(pos, parent);
					pos = parent;
				end
			end
		end
		res.occupancy = CNT_BITS'(heap_size);
		return res;
	endfunction

	// Compare accepted results first: they always belong to earlier requests.
	always @(posedge clk or negedge arst_n) begin
		int           bad;
		heap_result_t want;
		bad = 0;
		if (!arst_n) begin
			heap_size = 0;
			result_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result with no request outstanding (status %0d)", status);
					bad++;
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						bad++;
					end
					if (min_key !== want.min_key) begin
						$error("min_key: expected %0d, actual %0d", want.min_key, min_key);
						bad++;
					end
					if (min_source !== want.min_source) begin
						$error("min_source: expected %0d, actual %0d", want.min_source,
							min_source);
						bad++;
					end
					if (occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d", want.occupancy,
							occupancy);
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(apply_request(op, key, source));
			pending <= result_q.size();
			errors <= errors + bad;
		end
	end

endmodule

### tb/sv/k_way_merge_min_heap_test.sv
// Stimulus and verdict for the k-way merge min-heap, with the checker beside the block.
module k_way_merge_min_heap_test;
	import kwm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       op = OP_INSERT;
	logic signed [KEY_BITS-1:0] key = '0;
	logic [SRC_BITS-1:0]        source = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [STS_BITS-1:0]        status;
	logic signed [KEY_BITS-1:0] min_key;
	logic [SRC_BITS-1:0]        min_source;
	logic [CNT_BITS-1:0]        occupancy;
	int                         pending;
	int                         errors;

	// Set during the stretch in which neither side idles.
	logic calm = 1'b0;
	// Entry count as seen from the sender, used only to steer the stimulus.
	int   level = 0;
	int   stall_cycles = 0;

	always #6 clk = ~clk;

	k_way_merge_min_heap dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.source     (source),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.min_key    (min_key),
		.min_source (min_source),
		.occupancy  (occupancy)
	);

	k_way_merge_min_heap_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.source     (source),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.min_key    (min_key),
		.min_source (min_source),
		.occupancy  (occupancy),
		.pending    (pending),
		.errors     (errors)
	);

	// The receiver stalls about a fifth of the time outside the calm stretch.
	always @(negedge clk)
		out_ready = calm || ($urandom_range(99) >= 20);

	// Watchdog on cycles in which neither channel moves a request or result.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Keys lean toward the extremes and a narrow band that forces ties.
	function automatic logic signed [KEY_BITS-1:0] pick_key();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return KEY_BITS'($signed($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so a following request keeps it up.
	task automatic put_request(input logic op_v, input logic signed [KEY_BITS-1:0] key_v,
			input logic [SRC_BITS-1:0] src_v);
		if (!calm && $urandom_range(99) < 20) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		op = op_v;
		key = key_v;
		source = src_v;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (op_v == OP_INSERT) begin
			if (level < MAX_LISTS)
				level++;
		end else if (level > 0) begin
			level--;
		end
	endtask

	task automatic put_extract();
		put_request(OP_EXTRACT, $urandom, SRC_BITS'($urandom));
	endtask

	task automatic put_random_insert();
		put_request(OP_INSERT, pick_key(), SRC_BITS'($urandom));
	endtask

	// Holds the sender off until every owed result has been taken.
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int pct;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty extract, extreme keys, tied keys, then empty it again.
		put_extract();
		put_request(OP_INSERT, 32'sh7FFF_FFFF, 8'hFF);
		put_request(OP_INSERT, 32'sh8000_0000, 8'h00);
		put_request(OP_INSERT, 32'sh0000_0000, 8'hAA);
		put_request(OP_INSERT, -32'sd1, 8'h55);
		put_request(OP_INSERT, 32'sd7, 8'd1);
		put_request(OP_INSERT, 32'sd7, 8'd2);
		put_request(OP_INSERT, 32'sd7, 8'd3);
		put_request(OP_INSERT, 32'sh8000_0001, 8'd9);
		repeat (9) put_extract();
		drain_results();

		// Random mix that sweeps the occupancy up and down.
		for (int i = 0; i < 600; i++) begin
			pct = ((i / 100) % 2 == 0) ? 70 : 35;
			if ($urandom_range(99) < pct)
				put_random_insert();
			else
				put_extract();
		end
		drain_results();

		// Fill to capacity, push against the full heap, then drain past empty.
		while (level < MAX_LISTS)
			put_random_insert();
		repeat (3) put_random_insert();
		drain_results();
		while (level > 0)
			put_extract();
		repeat (2) put_extract();
		drain_results();

		// Long stretch with neither side idling.
		calm = 1'b1;
		for (int i = 0; i < 350; i++) begin
			if ($urandom_range(99) < 55)
				put_random_insert();
			else
				put_extract();
		end
		in_valid = 1'b0;
		calm = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
sv/kwm_pkg.sv
sv/kwm_ram.sv
sv/kwm_dp.sv
sv/kwm_ctrl.sv
sv/k_way_merge_min_heap.sv
tb/sv/k_way_merge_min_heap_check.sv
tb/sv/k_way_merge_min_heap_test.sv
